/* design/ccs_pkg.sv */
// Package for the capture chunk scheduler: types, codes and constants.
package ccs_pkg;

  localparam int QueueDepthDefault = 16;
  localparam logic [15:0] DryLimitReset = 16'd1000;
  localparam logic [6:0] PollPeriodReset = 7'd100;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_POLL    = 2'd2,
    CMD_HALT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_PURGE = 2'd2,
    KIND_ALARM = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_HWM    = 2'd0,
    REG_WINDOW = 2'd1,
    REG_DRY    = 2'd2,
    REG_POLL   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  chunk_id;
    logic [7:0]  parent_id;
    logic [63:0] first_sample;
    logic [63:0] last_sample;
    logic        parent_dead;
    logic        setup_ok;
    logic        new_data;
    logic [63:0] head_position;
    logic [63:0] start_tail;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_chunk;
    logic [63:0] purge_amount;
    logic [63:0] tail_now;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_REJ_SCAN,
    ST_REJ_SHIFT,
    ST_REJ_NEW,
    ST_CMP_HEAD,
    ST_SIB_SCAN,
    ST_SIB_SHIFT,
    ST_DONE_SHIFT,
    ST_PURGE,
    ST_ALARM,
    ST_DRAIN
  } state_t;

  // Shared compare unit request: one 64-bit magnitude compare a cycle.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic le;  // a <= b
    logic lt;  // a < b
    logic eq;
  } cmp_rsp_t;

endpackage

/* design/ccs_cmp.sv */
// Shared 64-bit compare unit used by the scheduler sequencer.
module ccs_cmp
  import ccs_pkg::*;
(
  input  cmp_req_t req,
  output cmp_rsp_t rsp
);

  always_comb begin
    rsp.lt = req.a < req.b;
    rsp.eq = req.a == req.b;
    rsp.le = rsp.lt | rsp.eq;
  end

endmodule

/* design/capture_chunk_scheduler_unit.sv */
// Capture chunk scheduler: queue sequencer, config registers and result port.
// A start command completes without raising busy; an enqueue scans for its slot
// and then shifts. Each removal shifts the queue one entry a cycle.
// One command at a time; busy holds through the final result beat, which is
// shown as the sequencer returns to idle. Results last one cycle, no stall.
// Synchronous active-high reset clears control state, not queue storage.
module capture_chunk_scheduler_unit
  import ccs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   item,
  output logic       result_valid,
  output out_item_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Configuration registers.
  logic [31:0] hwm_samples, window_samples;
  logic [15:0] dry_limit;
  logic [6:0]  poll_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hwm_samples    <= '0;
      window_samples <= '0;
      dry_limit      <= DryLimitReset;
      poll_period    <= PollPeriodReset;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_HWM:    hwm_samples    <= cfg_data;
        REG_WINDOW: window_samples <= cfg_data;
        REG_DRY:    dry_limit      <= cfg_data[15:0];
        REG_POLL:   poll_period    <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  // Queue storage, one entry moved per cycle by the sequencer.
  logic [7:0]  q_tag    [QUEUE_DEPTH];
  logic [7:0]  q_parent [QUEUE_DEPTH];
  logic [63:0] q_first  [QUEUE_DEPTH];
  logic [63:0] q_last   [QUEUE_DEPTH];

  state_t      state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;      // scan or shift position
  logic [CW-1:0] pos;      // insertion point
  logic [63:0] ring_tail, high_water;
  logic [16:0] dry_counter;
  logic        running;
  in_item_t    cur;
  logic [7:0]  sib_parent;
  logic        draining;    // drain sequence, return to ST_DRAIN after siblings

  // Result formed this cycle, and the one beat held back so the final beat of
  // a command can be marked once the sequencer knows nothing follows.
  logic        gen_valid;
  out_item_t   gen;
  logic        pend_valid;
  out_item_t   pend;

  logic [IW-1:0] ia, ia1;
  assign ia  = idx[IW-1:0];
  assign ia1 = IW'(idx + CW'(1));

  cmp_req_t creq;
  cmp_rsp_t crsp;
  ccs_cmp u_cmp (.req(creq), .rsp(crsp));

  // Purge low mark, computed from the latched head.
  logic [63:0] lwm;
  assign lwm = (cur.head_position > {32'd0, window_samples}) ?
               cur.head_position - {32'd0, window_samples} : 64'd0;

  logic idx_in;
  assign idx_in = idx < count;

  // Compare operand selection.
  always_comb begin
    creq = '0;
    unique case (state)
      ST_INS_SCAN: begin
        creq.a = q_last[ia];
        creq.b = cur.last_sample;
      end
      ST_CMP_HEAD: begin
        creq.a = q_last[0];
        creq.b = cur.head_position;
      end
      ST_PURGE: begin
        creq.a = cur.head_position;
        creq.b = high_water;
      end
      default: ;
    endcase
  end

  logic sib_hit;
  assign sib_hit = idx_in && (q_parent[ia] == sib_parent);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !busy) begin
          unique case (cmd_t'(item.cmd))
            CMD_START: state_next = ST_IDLE;
            CMD_ENQUEUE: begin
              if (!running || item.parent_dead || !item.setup_ok)
                state_next = ST_REJ_SCAN;
              else if (count >= DEPTH_C)
                state_next = ST_REJ_NEW;
              else
                state_next = ST_INS_SCAN;
            end
            CMD_POLL: begin
              if (!running) state_next = ST_IDLE;
              else if (item.new_data) state_next = ST_CMP_HEAD;
              else state_next = ST_ALARM;
            end
            default: state_next = running ? ST_DRAIN : ST_IDLE;
          endcase
        end
      end
      ST_INS_SCAN:
        if (!idx_in || !crsp.le) state_next = ST_INS_SHIFT;
      ST_INS_SHIFT:
        if (idx <= pos) state_next = ST_IDLE;
      ST_REJ_SCAN:
        if (!idx_in) state_next = ST_REJ_NEW;
        else if (sib_hit) state_next = ST_REJ_SHIFT;
      ST_REJ_SHIFT:
        if (idx + CW'(1) >= count) state_next = ST_REJ_SCAN;
      ST_REJ_NEW: state_next = ST_IDLE;
      ST_CMP_HEAD: begin
        if (count == '0 || !crsp.le) state_next = ST_PURGE;
        else if (q_first[0] < ring_tail) state_next = ST_SIB_SCAN;
        else state_next = ST_DONE_SHIFT;
      end
      ST_DONE_SHIFT:
        if (idx + CW'(1) >= count) state_next = ST_CMP_HEAD;
      ST_SIB_SCAN:
        if (!idx_in) state_next = draining ? ST_DRAIN : ST_CMP_HEAD;
        else if (sib_hit) state_next = ST_SIB_SHIFT;
      ST_SIB_SHIFT:
        if (idx + CW'(1) >= count) state_next = ST_SIB_SCAN;
      ST_PURGE: state_next = ST_ALARM;
      ST_ALARM: state_next = (dry_counter == '0) ? ST_DRAIN : ST_IDLE;
      ST_DRAIN: state_next = (count == '0) ? ST_IDLE : ST_SIB_SCAN;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic: result formed by the current sequencer step.
  always_comb begin
    gen_valid = 1'b0;
    gen       = '0;
    gen.tail_now = ring_tail;
    unique case (state)
      ST_REJ_SCAN: if (sib_hit) begin
        gen_valid     = 1'b1;
        gen.kind      = KIND_ERROR;
        gen.out_chunk = q_tag[ia];
      end
      ST_REJ_NEW: begin
        gen_valid     = 1'b1;
        gen.kind      = KIND_ERROR;
        gen.out_chunk = cur.chunk_id;
      end
      ST_CMP_HEAD: if (count != '0 && crsp.le && !(q_first[0] < ring_tail)) begin
        gen_valid     = 1'b1;
        gen.kind      = KIND_DONE;
        gen.out_chunk = q_tag[0];
      end
      ST_SIB_SCAN: if (sib_hit) begin
        gen_valid     = 1'b1;
        gen.kind      = KIND_ERROR;
        gen.out_chunk = q_tag[ia];
      end
      ST_PURGE: if (!crsp.le && lwm > ring_tail) begin
        gen_valid        = 1'b1;
        gen.kind         = KIND_PURGE;
        gen.purge_amount = lwm - ring_tail;
        gen.tail_now     = lwm;
      end
      ST_ALARM: if (dry_counter == '0) begin
        gen_valid = 1'b1;
        gen.kind  = KIND_ALARM;
      end
      default: ;
    endcase
  end

  // Release the held beat when a newer one replaces it, or once the
  // sequencer is back in idle, where it is the final beat of the command.
  assign result_valid = pend_valid && (gen_valid || state == ST_IDLE);

  always_comb begin
    result      = pend;
    result.last = (state == ST_IDLE);
  end

  assign busy = (state != ST_IDLE) || pend_valid;

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      ring_tail   <= '0;
      high_water  <= '0;
      dry_counter <= '0;
      running     <= 1'b0;
      draining    <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (gen_valid) begin
        pend_valid <= 1'b1;
        pend       <= gen;
      end else if (state == ST_IDLE) begin
        pend_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (start && !busy) begin
          cur        <= item;
          idx        <= '0;
          sib_parent <= item.parent_id;
          draining   <= 1'b0;
          unique case (cmd_t'(item.cmd))
            CMD_START: begin
              running     <= 1'b1;
              ring_tail   <= item.start_tail;
              high_water  <= item.start_tail + {32'd0, hwm_samples};
              dry_counter <= {1'b0, dry_limit};
            end
            CMD_POLL: if (running) begin
              if (item.new_data) begin
                dry_counter <= {1'b0, dry_limit};
              end else begin
                dry_counter <= (dry_counter > {10'd0, poll_period}) ?
                               dry_counter - {10'd0, poll_period} : '0;
              end
            end
            default: ;
          endcase
        end
        ST_INS_SCAN: begin
          if (idx_in && crsp.le) idx <= idx + CW'(1);
          else begin
            pos <= idx;
            idx <= count;
          end
        end
        ST_INS_SHIFT: begin
          if (idx > pos) begin
            q_tag[ia]    <= q_tag[IW'(idx - CW'(1))];
            q_parent[ia] <= q_parent[IW'(idx - CW'(1))];
            q_first[ia]  <= q_first[IW'(idx - CW'(1))];
            q_last[ia]   <= q_last[IW'(idx - CW'(1))];
            idx <= idx - CW'(1);
          end else begin
            q_tag[ia]    <= cur.chunk_id;
            q_parent[ia] <= cur.parent_id;
            q_first[ia]  <= cur.first_sample;
            q_last[ia]   <= cur.last_sample;
            count        <= count + CW'(1);
          end
        end
        ST_REJ_SCAN, ST_SIB_SCAN: begin
          if (idx_in && !sib_hit) idx <= idx + CW'(1);
        end
        ST_REJ_SHIFT, ST_SIB_SHIFT, ST_DONE_SHIFT: begin
          if (idx + CW'(1) < count) begin
            q_tag[ia]    <= q_tag[ia1];
            q_parent[ia] <= q_parent[ia1];
            q_first[ia]  <= q_first[ia1];
            q_last[ia]   <= q_last[ia1];
            idx <= idx + CW'(1);
          end else begin
            count <= count - CW'(1);
            idx   <= (state == ST_DONE_SHIFT) ? '0 : pos;
          end
        end
        ST_CMP_HEAD: begin
          idx <= '0;
          if (count != '0 && crsp.le && q_first[0] < ring_tail)
            sib_parent <= q_parent[0];
        end
        ST_PURGE: if (!crsp.le && lwm > ring_tail) begin
          ring_tail  <= lwm;
          high_water <= lwm + {32'd0, hwm_samples};
        end
        ST_ALARM: if (dry_counter == '0) draining <= 1'b1;
        ST_DRAIN: begin
          idx        <= '0;
          draining   <= 1'b1;
          sib_parent <= q_parent[0];
          if (count == '0) running <= 1'b0;
        end
        default: ;
      endcase
      // Hold the scan position across a shift so the next scan resumes there.
      if ((state == ST_REJ_SCAN || state == ST_SIB_SCAN) && sib_hit) pos <= idx;
    end
  end

endmodule
